@@ sv/biq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types, widths and saturation helpers for the biquad filter unit.
// ----------------------------------------------------------------------------
package biq_pkg;

  // Field and coefficient widths.
  localparam int CHAN_W    = 3;
  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 32;
  localparam int STATE_W   = 32;
  localparam int CFG_IDX_W = 3;

  // Products are Q4.28 times Q.23, rounded back to Q.23.
  localparam int PROD_W    = 2 * COEF_W;
  localparam int FRAC_SH   = 28;
  localparam int RND_W     = PROD_W - FRAC_SH;
  localparam int ACC_W     = 40;

  // Reset value of feed_gain_0 is 1.0 in Q4.28.
  localparam logic signed [COEF_W-1:0] FEED_GAIN_0_RESET = 32'sh1000_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FEED_GAIN_0 = 3'd0,
    REG_FEED_GAIN_1 = 3'd1,
    REG_FEED_GAIN_2 = 3'd2,
    REG_BACK_GAIN_1 = 3'd3,
    REG_BACK_GAIN_2 = 3'd4
  } cfg_idx_t;

  // Sequencer states: one multiply is issued in each working state.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MA0,
    S_MA1,
    S_MB1,
    S_MA2,
    S_WB
  } state_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [2:0] {
    OP_A0_X,
    OP_A1_X,
    OP_A2_X,
    OP_B1_Y,
    OP_B2_Y
  } mul_op_t;

  // Clamp an accumulator value to the signed 32-bit range.
  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sd2147483647);
    lo = -ACC_W'(64'sd2147483648);
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[STATE_W-1:0];
    end
  endfunction

  // Clamp a 32-bit value to the Q1.23 sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [STATE_W-1:0] v);
    if (v > 32'sd8388607) begin
      sat24 = 24'sh7F_FFFF;
    end else if (v < -32'sd8388608) begin
      sat24 = 24'sh80_0000;
    end else begin
      sat24 = v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

@@ sv/biquad_iir_filter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_iir_filter_unit
// Multi-channel transposed direct form II biquad with one shared multiplier.
// ----------------------------------------------------------------------------
// One sample is in flight at a time. A sample is taken in the idle cycle, its
// channel state is read from RAM in the next, and the five coefficient
// products are then formed one per cycle on a single 32x32 multiplier; the
// result is offered in the same cycle in which the next sample can be taken.
// The last step waits while the previous result has not been taken. The
// delay state of every channel reads as zero after reset through per-channel
// valid bits; there is no clearing pass. Coefficients are written through
// the cfg port, which is always ready; writes to unknown indexes are
// dropped. Samples on channels at or above CHANNELS leave the state alone
// and return zero.
// ----------------------------------------------------------------------------
module biquad_iir_filter_unit #(
  parameter int CHANNELS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Sample input
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [biq_pkg::CHAN_W-1:0]              in_chan,
  input  logic signed [biq_pkg::SAMPLE_W-1:0]     in_sample_in,
  // Filtered output
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [biq_pkg::CHAN_W-1:0]              out_chan_out,
  output logic signed [biq_pkg::SAMPLE_W-1:0]     out_sample_out,
  // Coefficient writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [biq_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [biq_pkg::COEF_W-1:0]              cfg_data
);
  import biq_pkg::*;

  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W = 7;
  localparam int RAM_W = 2 * STATE_W;

  // Coefficients.
  logic signed [COEF_W-1:0] feed_gain_0_r, feed_gain_1_r, feed_gain_2_r;
  logic signed [COEF_W-1:0] back_gain_1_r, back_gain_2_r;

  // Sequencer and datapath registers.
  state_t                     state_r, state_nxt;
  logic [CHAN_W-1:0]          chan_r, chan_nxt;
  logic [AW-1:0]              addr_r, addr_nxt;
  logic                       bad_r, bad_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic signed [STATE_W-1:0]  z1_r, z1_nxt;
  logic signed [STATE_W-1:0]  z2_r, z2_nxt;
  logic signed [STATE_W-1:0]  y_r, y_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic [CHANNELS-1:0]        vld_r, vld_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0]          out_chan_r, out_chan_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;

  // Control from the output decoder.
  logic                       mul_en;
  mul_op_t                    mul_op;
  logic                       wb_fire;

  logic                       in_fire;
  logic [EXT_W-1:0]           chan_ext;
  logic                       in_bad;
  logic [RAM_W-1:0]           ram_rdata;
  logic signed [COEF_W-1:0]   mul_coef;
  logic signed [STATE_W-1:0]  mul_opnd;
  logic signed [RND_W-1:0]    rnd;
  logic signed [ACC_W-1:0]    rnd_ext;
  logic signed [STATE_W-1:0]  z2_new;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign chan_ext  = EXT_W'(in_chan);
  assign in_bad    = (chan_ext >= EXT_W'(CHANNELS));
  assign rnd_ext   = ACC_W'(rnd);
  assign z2_new    = sat32(acc_r - rnd_ext);

  assign out_valid      = out_valid_r;
  assign out_chan_out   = out_chan_r;
  assign out_sample_out = out_sample_r;

  // Coefficient register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed_gain_0_r <= FEED_GAIN_0_RESET;
      feed_gain_1_r <= '0;
      feed_gain_2_r <= '0;
      back_gain_1_r <= '0;
      back_gain_2_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FEED_GAIN_0: feed_gain_0_r <= cfg_data;
        REG_FEED_GAIN_1: feed_gain_1_r <= cfg_data;
        REG_FEED_GAIN_2: feed_gain_2_r <= cfg_data;
        REG_BACK_GAIN_1: back_gain_1_r <= cfg_data;
        REG_BACK_GAIN_2: back_gain_2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_MA0;
      S_MA0:   state_nxt = S_MA1;
      S_MA1:   state_nxt = S_MB1;
      S_MB1:   state_nxt = S_MA2;
      S_MA2:   state_nxt = S_WB;
      S_WB:    if (wb_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output decode: which product to issue, and when the write-back completes.
  always_comb begin
    mul_en  = 1'b0;
    mul_op  = OP_A0_X;
    wb_fire = 1'b0;
    case (state_r)
      S_LOAD: begin
        mul_en = 1'b1;
        mul_op = OP_A0_X;
      end
      S_MA0: begin
        mul_en = 1'b1;
        mul_op = OP_A1_X;
      end
      S_MA1: begin
        mul_en = 1'b1;
        mul_op = OP_B1_Y;
      end
      S_MB1: begin
        mul_en = 1'b1;
        mul_op = OP_A2_X;
      end
      S_MA2: begin
        mul_en = 1'b1;
        mul_op = OP_B2_Y;
      end
      S_WB:    wb_fire = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_coef = feed_gain_0_r;
    mul_opnd = STATE_W'(x_r);
    case (mul_op)
      OP_A0_X: begin
        mul_coef = feed_gain_0_r;
        mul_opnd = STATE_W'(x_r);
      end
      OP_A1_X: begin
        mul_coef = feed_gain_1_r;
        mul_opnd = STATE_W'(x_r);
      end
      OP_A2_X: begin
        mul_coef = feed_gain_2_r;
        mul_opnd = STATE_W'(x_r);
      end
      OP_B1_Y: begin
        mul_coef = back_gain_1_r;
        mul_opnd = y_r;
      end
      OP_B2_Y: begin
        mul_coef = back_gain_2_r;
        mul_opnd = y_r;
      end
      default: ;
    endcase
  end

  // Datapath: the load state takes the channel state, and each multiply state after it folds the previous product in.
  always_comb begin
    chan_nxt       = chan_r;
    addr_nxt       = addr_r;
    bad_nxt        = bad_r;
    x_nxt          = x_r;
    z1_nxt         = z1_r;
    z2_nxt         = z2_r;
    y_nxt          = y_r;
    acc_nxt        = acc_r;
    vld_nxt        = vld_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_chan_nxt   = out_chan_r;
    out_sample_nxt = out_sample_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          chan_nxt = in_chan;
          addr_nxt = chan_ext[AW-1:0];
          bad_nxt  = in_bad;
          x_nxt    = in_sample_in;
        end
      end
      // Channel state arrives from RAM; unwritten channels read as zero.
      S_LOAD: begin
        if (vld_r[addr_r]) begin
          z1_nxt = ram_rdata[RAM_W-1:STATE_W];
          z2_nxt = ram_rdata[STATE_W-1:0];
        end else begin
          z1_nxt = '0;
          z2_nxt = '0;
        end
      end
      S_MA0: y_nxt   = sat32(rnd_ext + ACC_W'(z1_r));
      S_MA1: acc_nxt = rnd_ext + ACC_W'(z2_r);
      S_MB1: acc_nxt = acc_r - rnd_ext;
      S_MA2: begin
        z1_nxt  = sat32(acc_r);
        acc_nxt = rnd_ext;
      end
      S_WB: begin
        if (wb_fire) begin
          out_valid_nxt  = 1'b1;
          out_chan_nxt   = chan_r;
          out_sample_nxt = bad_r ? '0 : sat24(y_r);
          if (!bad_r) begin
            vld_nxt[addr_r] = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    chan_r       <= chan_nxt;
    addr_r       <= addr_nxt;
    bad_r        <= bad_nxt;
    x_r          <= x_nxt;
    z1_r         <= z1_nxt;
    z2_r         <= z2_nxt;
    y_r          <= y_nxt;
    acc_r        <= acc_nxt;
    out_chan_r   <= out_chan_nxt;
    out_sample_r <= out_sample_nxt;
  end

  // Shared multiplier.
  biq_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .coef (mul_coef),
    .opnd (mul_opnd),
    .rnd  (rnd)
  );

  // Per-channel delay state: {z1, z2}.
  biq_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_state_ram (
    .clk   (clk),
    .we    (wb_fire && !bad_r),
    .waddr (addr_r),
    .wdata ({z1_r, z2_new}),
    .re    (in_fire),
    .raddr (chan_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

endmodule

@@ sv/biq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module biq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/biq_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_mul
// Shared 32x32 signed multiplier with a product register and Q.23 rounding.
// ----------------------------------------------------------------------------
module biq_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [biq_pkg::COEF_W-1:0]    coef,
  input  logic signed [biq_pkg::STATE_W-1:0]   opnd,
  output logic signed [biq_pkg::RND_W-1:0]     rnd
);
  import biq_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(64'sd1 <<< (FRAC_SH - 1));

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] sum;

  // The product holds until the next multiply is issued.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(coef) * PROD_W'(opnd);
    end
  end

  // Round half up: add one half, then drop the fraction bits (floor).
  always_comb begin
    sum = prod_r + HALF;
    rnd = sum[PROD_W-1:FRAC_SH];
  end

endmodule

@@ dv/biquad_iir_filter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_iir_filter_unit_tb
// Self-checking bench for the multi-channel biquad filter unit.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the five gains and of the delay
// pair of every channel. It computes the filtered sample for each accepted
// input transfer and compares every output transfer against the oldest
// prediction. A short directed run covers full-scale samples on every channel
// and extreme gains. Random phases follow, each with a fresh gain set written
// while the unit is idle. The sender works in bursts, and the sink stalls in
// patterns of its own. A watchdog ends the run when transfers stop.
// ----------------------------------------------------------------------------
module biquad_iir_filter_unit_tb;
  import biq_pkg::*;

  localparam int CHANNELS       = 8;
  localparam int NUM_GAINS      = int'(REG_BACK_GAIN_2) + 1;
  localparam int CFG_IDX_TOP    = (1 << CFG_IDX_W) - 1;
  localparam int RESET_CYCLES   = 5;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 40;
  localparam int PHASE_ITEMS    = 85;

  localparam longint ROUND_BIAS = 64'sd1 <<< (FRAC_SH - 1);
  localparam longint STATE_MAX  = (64'sd1 <<< (STATE_W - 1)) - 1;
  localparam longint STATE_MIN  = -(64'sd1 <<< (STATE_W - 1));
  localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_W - 1));

  localparam logic signed [SAMPLE_W-1:0] X_MAX = 24'sh7F_FFFF;
  localparam logic signed [SAMPLE_W-1:0] X_MIN = 24'sh80_0000;
  localparam logic [COEF_W-1:0] GAIN_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] GAIN_MIN = 32'h8000_0000;

  typedef logic [COEF_W-1:0] gain_set_t [NUM_GAINS];

  typedef enum int {
    GAINS_RESET,
    GAINS_ZERO,
    GAINS_STABLE,
    GAINS_MAX,
    GAINS_MIN,
    GAINS_WIDE,
    GAINS_MODERATE
  } gain_mode_e;

  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_PERIODIC,
    SINK_BURSTY
  } sink_mode_e;

  typedef struct {
    logic [CHAN_W-1:0]          chan;
    logic signed [SAMPLE_W-1:0] sample;
  } filtered_t;

  // Scoreboard: filter state, gain copy and the queue of predicted samples.
  class filter_scoreboard;
    logic signed [COEF_W-1:0]  gain [NUM_GAINS];
    logic signed [STATE_W-1:0] delay_one [CHANNELS];
    logic signed [STATE_W-1:0] delay_two [CHANNELS];
    filtered_t                 expected_q [$];
    int                        errors;

    function new();
      for (int i = 0; i < NUM_GAINS; i++) begin
        gain[i] = '0;
      end
      gain[REG_FEED_GAIN_0] = FEED_GAIN_0_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        delay_one[c] = '0;
        delay_two[c] = '0;
      end
      errors = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) begin
        return lo;
      end
      if (v > hi) begin
        return hi;
      end
      return v;
    endfunction

    // Exact Q4.28 by Q.23 product, rounded half up back to Q.23.
    function longint product(longint c, longint operand);
      return (c * operand + ROUND_BIAS) >>> FRAC_SH;
    endfunction

    // Writes to indexes past the last gain are dropped by the unit.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      if (idx < NUM_GAINS) begin
        gain[idx] = data;
      end
    endfunction

    // Run one sample through the channel's filter and queue the result.
    function void note_sample(logic [CHAN_W-1:0] ch, logic signed [SAMPLE_W-1:0] x);
      longint    xv;
      longint    yv;
      longint    z1;
      longint    z2;
      filtered_t item;
      item.chan = ch;
      if (ch >= CHANNELS) begin
        item.sample = '0;
      end else begin
        xv = x;
        yv = clamp(product(gain[REG_FEED_GAIN_0], xv) + delay_one[ch], STATE_MIN, STATE_MAX);
        z1 = product(gain[REG_FEED_GAIN_1], xv) + delay_two[ch]
             - product(gain[REG_BACK_GAIN_1], yv);
        z2 = product(gain[REG_FEED_GAIN_2], xv) - product(gain[REG_BACK_GAIN_2], yv);
        delay_one[ch] = clamp(z1, STATE_MIN, STATE_MAX);
        delay_two[ch] = clamp(z2, STATE_MIN, STATE_MAX);
        item.sample = clamp(yv, SAMPLE_MIN, SAMPLE_MAX);
      end
      expected_q.push_back(item);
    endfunction

    // Compare one output transfer with the oldest prediction.
    function void check_result(logic [CHAN_W-1:0] ch, logic signed [SAMPLE_W-1:0] y);
      filtered_t item;
      if (expected_q.size() == 0) begin
        if (errors < MAX_REPORTS) begin
          $display("%0t: unexpected output on channel %0d, sample %0d", $time, ch, y);
        end
        errors++;
        return;
      end
      item = expected_q.pop_front();
      if (item.chan !== ch) begin
        if (errors < MAX_REPORTS) begin
          $display("%0t: chan_out mismatch: expected %0d, actual %0d", $time, item.chan, ch);
        end
        errors++;
      end
      if (item.sample !== y) begin
        if (errors < MAX_REPORTS) begin
          $display("%0t: sample_out mismatch on channel %0d: expected %0d, actual %0d",
                   $time, item.chan, item.sample, y);
        end
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [CHAN_W-1:0]          in_chan;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       out_valid;
  logic                       out_ready;
  logic [CHAN_W-1:0]          out_chan_out;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [COEF_W-1:0]          cfg_data;

  filter_scoreboard sb;
  int               burst_left = 0;
  int               idle_cycles = 0;
  sink_mode_e       sink_mode = SINK_OPEN;
  int               mode_left = 0;
  int               stall_left = 0;
  int               period = 4;
  int               tick = 0;

  biquad_iir_filter_unit #(
    .CHANNELS(CHANNELS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_chan       (in_chan),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_chan_out  (out_chan_out),
    .out_sample_out(out_sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Free-running clock with a 10 ns period.
  always #5 clk = ~clk;

  // Pick a gain set for one phase of the run.
  function automatic gain_set_t pick_gains(gain_mode_e mode);
    gain_set_t g;
    for (int i = 0; i < NUM_GAINS; i++) begin
      case (mode)
        GAINS_RESET:    g[i] = (i == int'(REG_FEED_GAIN_0)) ? FEED_GAIN_0_RESET : '0;
        GAINS_ZERO:     g[i] = '0;
        GAINS_MAX:      g[i] = GAIN_MAX;
        GAINS_MIN:      g[i] = GAIN_MIN;
        GAINS_WIDE:     g[i] = $urandom();
        GAINS_MODERATE: g[i] = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
        default:        g[i] = '0;
      endcase
    end
    // Low-pass with poles at radius sqrt(0.4) and a DC gain of two.
    if (mode == GAINS_STABLE) begin
      g[REG_FEED_GAIN_0] = 32'd53687091;
      g[REG_FEED_GAIN_1] = 32'd107374182;
      g[REG_FEED_GAIN_2] = 32'd53687091;
      g[REG_BACK_GAIN_1] = 32'hF000_0000;
      g[REG_BACK_GAIN_2] = 32'd107374182;
    end
    return g;
  endfunction

  // Full-range random samples half of the time, with full-scale and near-zero values mixed in.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0:       return X_MAX;
      1:       return X_MIN;
      2, 3:    return SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  // Write every gain, then every unused index, one transfer at a time.
  task automatic load_gains(input gain_set_t g);
    logic [COEF_W-1:0] data;
    for (int idx = 0; idx <= CFG_IDX_TOP; idx++) begin
      data = (idx < NUM_GAINS) ? g[idx] : $urandom();
      cfg_valid <= 1'b1;
      cfg_index <= idx[CFG_IDX_W-1:0];
      cfg_data  <= data;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[CFG_IDX_W-1:0], data);
    end
    cfg_valid <= 1'b0;
  endtask

  // Offer one sample, opening a random gap whenever a burst runs out.
  task automatic push_sample(input logic [CHAN_W-1:0] ch,
                             input logic signed [SAMPLE_W-1:0] x);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_chan      <= ch;
    in_sample_in <= x;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(ch, x);
  endtask

  // Wait for every predicted sample, then let the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sink: check each output transfer, then choose the next ready value.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_chan_out, out_sample_out);
    end
    if (mode_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(50, 400);
      period = $urandom_range(2, 9);
    end
    mode_left--;
    tick++;
    case (sink_mode)
      SINK_OPEN:     out_ready <= 1'b1;
      SINK_COIN:     out_ready <= 1'($urandom_range(0, 1));
      SINK_PERIODIC: out_ready <= (tick % period) < (period / 2);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 19) == 0) begin
            stall_left = $urandom_range(10, 40);
          end
        end
      end
    endcase
  end

  // Watchdog: count cycles without any transfer on any channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed samples, then random phases.
  initial begin
    gain_mode_e plan [10];
    sb = new();
    plan = '{GAINS_STABLE, GAINS_WIDE, GAINS_MODERATE, GAINS_MAX, GAINS_STABLE,
             GAINS_MIN, GAINS_WIDE, GAINS_ZERO, GAINS_RESET, GAINS_MODERATE};
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_chan      <= '0;
    in_sample_in <= '0;
    out_ready    <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset gains pass samples through: zero, full scale, and one step each way.
    push_sample(3'd0, '0);
    push_sample(3'd0, X_MAX);
    push_sample(3'd0, X_MIN);
    push_sample(3'd0, -24'sd1);
    push_sample(3'd0, 24'sd1);
    for (int c = 1; c < CHANNELS; c++) begin
      push_sample(c[CHAN_W-1:0], (c % 2 == 1) ? X_MAX : X_MIN);
    end
    settle();

    // Largest positive gains drive the output and then the state into saturation.
    load_gains(pick_gains(GAINS_MAX));
    repeat (4) push_sample(3'd2, X_MAX);
    repeat (2) push_sample(3'd3, X_MIN);
    settle();

    // Most negative gains saturate the other way.
    load_gains(pick_gains(GAINS_MIN));
    repeat (3) push_sample(3'd4, X_MAX);
    repeat (3) push_sample(3'd5, X_MIN);
    settle();

    // Random phases, each with its own gain set.
    foreach (plan[p]) begin
      load_gains(pick_gains(plan[p]));
      repeat (PHASE_ITEMS) push_sample(CHAN_W'($urandom_range(0, CHANNELS - 1)), pick_sample());
      settle();
    end

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ biquad_iir_filter_unit.f @@
sv/biq_pkg.sv
sv/biq_ram.sv
sv/biq_mul.sv
sv/biquad_iir_filter_unit.sv
dv/biquad_iir_filter_unit_tb.sv
